FILE: design/fsba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fsba_pkg;

    localparam int NUM_SLOTS  = 16;
    localparam int NUM_BLOCKS = 512;

    localparam int ID_W        = 31;
    localparam int SLOT_IDX_W  = 4;
    localparam int BLOCK_NUM_W = 9;

    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int BLK_W     = $clog2(NUM_BLOCKS);
    localparam int WORD_W    = (NUM_BLOCKS < 32) ? NUM_BLOCKS : 32;
    localparam int BIT_W     = $clog2(WORD_W);
    localparam int NUM_WORDS = NUM_BLOCKS / WORD_W;
    localparam int WA_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_CREATE = 2'd1,
        OP_DELETE = 2'd2,
        OP_FORMAT = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EXISTS    = 3'd1,
        ST_NO_BLOCK  = 3'd2,
        ST_NO_SLOT   = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    // query travelling down the slot chain
    typedef struct packed {
        logic              live;
        logic [ID_W-1:0]   id;
        logic              hit;
        logic [SLOT_W-1:0] hit_slot;
        logic [BLK_W-1:0]  hit_block;
        logic              free;
        logic [SLOT_W-1:0] free_slot;
    } t_token;

    // update broadcast to every slot cell
    typedef struct packed {
        logic              set;
        logic              clr;
        logic              clr_all;
        logic [SLOT_W-1:0] idx;
        logic [ID_W-1:0]   id;
        logic [BLK_W-1:0]  block;
    } t_cell_cmd;

    typedef struct packed {
        logic             search;
        logic             set;
        logic             clr;
        logic             fmt;
        logic [BLK_W-1:0] block;
    } t_bm_cmd;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic             found;
        logic [BLK_W-1:0] block;
    } t_bm_stat;

    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] bit_idx;
    } t_zero;

    // lowest clear bit of a bitmap word
    function automatic t_zero first_zero(input logic [WORD_W-1:0] w);
        t_zero r;
        r = '0;
        for (int k = WORD_W - 1; k >= 0; k--) begin
            if (!w[k]) begin
                r.found   = 1'b1;
                r.bit_idx = BIT_W'(k);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: design/fsba_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface fsba_req_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    opcode;
    logic [fsba_pkg::ID_W-1:0]     file_id;

    modport source (output valid, output opcode, output file_id, input ready);
    modport sink   (input valid, input opcode, input file_id, output ready);
endinterface

interface fsba_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [2:0]                        status;
    logic [fsba_pkg::SLOT_IDX_W-1:0]   slot_index;
    logic [fsba_pkg::BLOCK_NUM_W-1:0]  data_block;

    modport source (output valid, output status, output slot_index, output data_block,
                    input ready);
    modport sink   (input valid, input status, input slot_index, input data_block,
                    output ready);
endinterface

`default_nettype wire

FILE: design/fsba_slot_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module fsba_slot_cell (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [fsba_pkg::SLOT_W-1:0] i_idx,
    input  wire fsba_pkg::t_token            i_tok,
    input  wire fsba_pkg::t_cell_cmd         i_cmd,
    output fsba_pkg::t_token                 o_tok
);

    logic                           r_valid;
    logic [fsba_pkg::ID_W-1:0]      r_id;
    logic [fsba_pkg::BLK_W-1:0]     r_block;
    fsba_pkg::t_token               r_tok;
    fsba_pkg::t_token               n_tok;
    logic                           w_hit_here;
    logic                           w_free_here;
    logic                           w_mine;

    assign w_mine      = (i_cmd.idx == i_idx);
    assign w_hit_here  = r_valid && (r_id == i_tok.id);
    assign w_free_here = !r_valid;

    always_comb begin
        n_tok = i_tok;
        if (!i_tok.hit && w_hit_here) begin
            n_tok.hit       = 1'b1;
            n_tok.hit_slot  = i_idx;
            n_tok.hit_block = r_block;
        end
        if (!i_tok.free && w_free_here) begin
            n_tok.free      = 1'b1;
            n_tok.free_slot = i_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.clr_all || (i_cmd.clr && w_mine)) begin
            r_valid <= 1'b0;
        end else if (i_cmd.set && w_mine) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.set && w_mine) begin
            r_id    <= i_cmd.id;
            r_block <= i_cmd.block;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.live <= 1'b0;
        end else begin
            r_tok.live <= i_tok.live;
        end
        r_tok.id        <= n_tok.id;
        r_tok.hit       <= n_tok.hit;
        r_tok.hit_slot  <= n_tok.hit_slot;
        r_tok.hit_block <= n_tok.hit_block;
        r_tok.free      <= n_tok.free;
        r_tok.free_slot <= n_tok.free_slot;
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

FILE: design/fsba_bitmap.sv
`timescale 1ns / 1ps
`default_nettype none

module fsba_bitmap (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire fsba_pkg::t_bm_cmd  i_cmd,
    output fsba_pkg::t_bm_stat      o_stat
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_RD   = 4'b0100,
        S_WR   = 4'b1000
    } t_bm_state;

    localparam logic [fsba_pkg::WA_W-1:0] LAST_WORD = fsba_pkg::WA_W'(fsba_pkg::NUM_WORDS - 1);

    logic [fsba_pkg::WORD_W-1:0]    mem [fsba_pkg::NUM_WORDS];
    logic [fsba_pkg::NUM_WORDS-1:0] r_row_ok;

    t_bm_state                      r_state;
    t_bm_state                      n_state;
    logic [fsba_pkg::WA_W-1:0]      r_addr;
    logic [fsba_pkg::WA_W-1:0]      r_daddr;
    logic                           r_dv;
    logic [fsba_pkg::WORD_W-1:0]    r_rdata;
    logic [fsba_pkg::BIT_W-1:0]     r_bit;
    logic                           r_setv;
    logic                           r_done;
    logic                           r_found;
    logic [fsba_pkg::BLK_W-1:0]     r_blk;

    logic [fsba_pkg::WORD_W-1:0]    w_word;
    logic [fsba_pkg::WORD_W-1:0]    w_wdata;
    fsba_pkg::t_zero                w_zero;
    logic                           w_wr_en;

    // rows never written read as their reset pattern: blocks 0 and 1 in use
    always_comb begin
        if (r_row_ok[r_daddr]) begin
            w_word = r_rdata;
        end else if (r_daddr == '0) begin
            w_word = fsba_pkg::WORD_W'(2'b11);
        end else begin
            w_word = '0;
        end
    end

    assign w_zero  = fsba_pkg::first_zero(w_word);
    assign w_wr_en = (r_state == S_WR);

    always_comb begin
        w_wdata        = w_word;
        w_wdata[r_bit] = r_setv;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_cmd.search) begin
                    n_state = S_SCAN;
                end else if (i_cmd.set || i_cmd.clr) begin
                    n_state = S_RD;
                end
            end
            S_SCAN: begin
                if (r_dv && (w_zero.found || r_daddr == LAST_WORD)) begin
                    n_state = S_IDLE;
                end
            end
            S_RD:    n_state = S_WR;
            S_WR:    n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[r_daddr] <= w_wdata;
        end
        r_rdata <= mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_dv     <= 1'b0;
            r_done   <= 1'b0;
            r_row_ok <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    r_dv <= 1'b0;
                    if (i_cmd.fmt) begin
                        r_row_ok <= '0;
                    end
                    if (i_cmd.search) begin
                        r_done <= 1'b0;
                    end
                end
                S_SCAN: begin
                    r_dv <= 1'b1;
                    if (r_dv && (w_zero.found || r_daddr == LAST_WORD)) begin
                        r_done <= 1'b1;
                    end
                end
                S_WR: begin
                    r_row_ok[r_daddr] <= 1'b1;
                end
                default: begin
                    r_dv <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_cmd.search) begin
                    r_addr <= '0;
                end else begin
                    r_addr <= fsba_pkg::WA_W'(i_cmd.block >> fsba_pkg::BIT_W);
                end
                r_bit  <= i_cmd.block[fsba_pkg::BIT_W-1:0];
                r_setv <= i_cmd.set;
            end
            S_SCAN: begin
                r_daddr <= r_addr;
                if (r_addr != LAST_WORD) begin
                    r_addr <= r_addr + 1'b1;
                end
                if (r_dv) begin
                    r_found <= w_zero.found;
                    r_blk   <= fsba_pkg::BLK_W'({r_daddr, w_zero.bit_idx});
                end
            end
            S_RD: begin
                r_daddr <= r_addr;
            end
            default: begin
                r_daddr <= r_daddr;
            end
        endcase
    end

    assign o_stat.busy  = (r_state != S_IDLE);
    assign o_stat.done  = r_done;
    assign o_stat.found = r_found;
    assign o_stat.block = r_blk;

endmodule

`default_nettype wire

FILE: design/file_slot_and_block_allocator.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  | dir | modport | payload
// i_req    | in  | sink    | opcode (2), file_id (31)
// o_rsp    | out | source  | status (3), slot_index (4), data_block (9)
//
// one request at a time; a lookup holds off the next request until its query has passed
// the slot chain, a create also until the bitmap scan has finished, and a delete or create
// that succeeds also until the bitmap write-back is done; a format skips the chain and goes
// straight to the result
// the slot chain depth and the one-word-per-cycle bitmap scan set how long a request takes
// synchronous active-low reset empties every slot and leaves blocks 0 and 1 in use
// a result waits in the output register while the next request is taken; a new
// result is only loaded once the previous one has gone out

module file_slot_and_block_allocator (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    fsba_req_if.sink    i_req,
    fsba_rsp_if.source  o_rsp
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_FIN    = 3'b100
    } t_state;

    t_state                            r_state;
    t_state                            n_state;
    fsba_pkg::t_opcode                 r_op;
    logic                              r_tail_done;
    fsba_pkg::t_token                  r_tail;

    // pending result
    fsba_pkg::t_status                 r_res_status;
    logic [fsba_pkg::SLOT_W-1:0]       r_res_slot;
    logic [fsba_pkg::BLK_W-1:0]        r_res_block;

    // output register
    logic                              r_out_valid;
    fsba_pkg::t_status                 r_out_status;
    logic [fsba_pkg::SLOT_IDX_W-1:0]   r_out_slot;
    logic [fsba_pkg::BLOCK_NUM_W-1:0]  r_out_block;

    fsba_pkg::t_token                  w_tok [fsba_pkg::NUM_SLOTS + 1];
    fsba_pkg::t_cell_cmd               w_cmd;
    fsba_pkg::t_bm_cmd                 w_bm_cmd;
    fsba_pkg::t_bm_stat                w_bm_stat;
    fsba_pkg::t_opcode                 w_in_op;
    logic                              w_accept;
    logic                              w_decide;
    logic                              w_load;
    fsba_pkg::t_token                  w_tail;

    assign w_in_op  = fsba_pkg::t_opcode'(i_req.opcode);
    assign i_req.ready = (r_state == S_IDLE) && !w_bm_stat.busy;
    assign w_accept = i_req.valid && i_req.ready;

    // the chain result is kept until the bitmap scan has also finished
    assign w_tail   = r_tail_done ? r_tail : w_tok[fsba_pkg::NUM_SLOTS];
    assign w_decide = (r_state == S_SEARCH)
                   && (r_tail_done || w_tok[fsba_pkg::NUM_SLOTS].live)
                   && ((r_op != fsba_pkg::OP_CREATE) || w_bm_stat.done);

    assign w_load = (r_state == S_FIN) && (!r_out_valid || o_rsp.ready);

    // query enters the first cell in the cycle the request transfers
    always_comb begin
        w_tok[0]      = '0;
        w_tok[0].live = w_accept && (w_in_op != fsba_pkg::OP_FORMAT);
        w_tok[0].id   = i_req.file_id;
    end

    for (genvar g = 0; g < fsba_pkg::NUM_SLOTS; g++) begin : g_cell
        fsba_slot_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (fsba_pkg::SLOT_W'(g)),
            .i_tok   (w_tok[g]),
            .i_cmd   (w_cmd),
            .o_tok   (w_tok[g + 1])
        );
    end

    fsba_bitmap u_bitmap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_bm_cmd),
        .o_stat  (w_bm_stat)
    );

    // updates to the slot cells and the bitmap
    always_comb begin
        w_cmd          = '0;
        w_bm_cmd       = '0;
        w_cmd.id       = r_tail.id;
        w_cmd.block    = w_bm_stat.block;
        w_cmd.idx      = w_tail.free_slot;
        w_bm_cmd.block = w_bm_stat.block;
        if (w_accept) begin
            w_cmd.clr_all   = (w_in_op == fsba_pkg::OP_FORMAT);
            w_bm_cmd.fmt    = (w_in_op == fsba_pkg::OP_FORMAT);
            w_bm_cmd.search = (w_in_op == fsba_pkg::OP_CREATE);
        end
        if (w_decide) begin
            w_cmd.id = w_tail.id;
            case (r_op)
                fsba_pkg::OP_CREATE: begin
                    if (!w_tail.hit && w_bm_stat.found && w_tail.free) begin
                        w_cmd.set    = 1'b1;
                        w_bm_cmd.set = 1'b1;
                    end
                end
                fsba_pkg::OP_DELETE: begin
                    if (w_tail.hit) begin
                        w_cmd.clr      = 1'b1;
                        w_cmd.idx      = w_tail.hit_slot;
                        w_bm_cmd.clr   = 1'b1;
                        w_bm_cmd.block = w_tail.hit_block;
                    end
                end
                default: begin
                    w_cmd.clr = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (w_in_op == fsba_pkg::OP_FORMAT) ? S_FIN : S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (w_decide) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tail_done <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_tail_done <= 1'b0;
            end else if (w_tok[fsba_pkg::NUM_SLOTS].live) begin
                r_tail_done <= 1'b1;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // decision on the finished query; the result starts as ok, slot 0, block 0
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op         <= w_in_op;
            r_res_status <= fsba_pkg::ST_OK;
            r_res_slot   <= '0;
            r_res_block  <= '0;
        end
        if (w_tok[fsba_pkg::NUM_SLOTS].live) begin
            r_tail <= w_tok[fsba_pkg::NUM_SLOTS];
        end
        if (w_decide) begin
            case (r_op)
                fsba_pkg::OP_CREATE: begin
                    if (w_tail.hit) begin
                        r_res_status <= fsba_pkg::ST_EXISTS;
                    end else if (!w_bm_stat.found) begin
                        r_res_status <= fsba_pkg::ST_NO_BLOCK;
                    end else if (!w_tail.free) begin
                        r_res_status <= fsba_pkg::ST_NO_SLOT;
                    end else begin
                        r_res_slot  <= w_tail.free_slot;
                        r_res_block <= w_bm_stat.block;
                    end
                end
                default: begin
                    // lookup and delete
                    if (w_tail.hit) begin
                        r_res_slot  <= w_tail.hit_slot;
                        r_res_block <= w_tail.hit_block;
                    end else begin
                        r_res_status <= fsba_pkg::ST_NOT_FOUND;
                    end
                end
            endcase
        end
        if (w_load) begin
            r_out_status <= r_res_status;
            r_out_slot   <= fsba_pkg::SLOT_IDX_W'(r_res_slot);
            r_out_block  <= fsba_pkg::BLOCK_NUM_W'(r_res_block);
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.slot_index = r_out_slot;
    assign o_rsp.data_block = r_out_block;

    // a failed request reports slot 0 and block 0
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status != fsba_pkg::ST_OK)
        |-> (o_rsp.slot_index == '0 && o_rsp.data_block == '0))
        else $error("failed request with nonzero slot or block");

    // only one request in flight
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !i_req.ready)
        else $error("request taken while another is in flight");

    // the query only leaves the chain while its request is being searched
    a_tail_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tok[fsba_pkg::NUM_SLOTS].live |-> (r_state == S_SEARCH))
        else $error("query left the chain outside a search");

    // blocks 0 and 1 are never handed out
    a_reserved_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_bm_stat.done && w_bm_stat.found)
        |-> (w_bm_stat.block != '0 && w_bm_stat.block != fsba_pkg::BLK_W'(1)))
        else $error("reserved block found free");

endmodule

`default_nettype wire
